/* src/binary_image_thinning_unit_defines.svh */
// ---------------------------------------------------------------------------
// binary image thinning unit - assertion macros
// shared assertion helpers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef BINARY_IMAGE_THINNING_UNIT_DEFINES_SVH
`define BINARY_IMAGE_THINNING_UNIT_DEFINES_SVH

`ifndef SYNTH
`define BITU_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define BITU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define BITU_ASSERT(label, clk, rst_n, cond, msg)
`define BITU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/bitu_pkg.sv */
// ---------------------------------------------------------------------------
// bitu_pkg
// types, constants and the per-pixel deletion test of the thinning unit
// ---------------------------------------------------------------------------
package bitu_pkg;

  localparam int unsigned ROW_BITS    = 64;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned PADDR_W     = 2;
  localparam logic [PADDR_W-1:0] REG_IMAGE_WIDTH = '0;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 7'd64;
  localparam int unsigned MIN_DIM     = 4;
  localparam logic [3:0] NB_MIN       = 4'd2;
  localparam logic [3:0] NB_MAX       = 4'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_THIN,
    ST_OUT
  } state_e;

  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } phase_e;

  // zhang-suen deletion test for one set pixel
  function automatic logic zs_delete(input logic ctr, input logic n, input logic ne,
                                     input logic ea, input logic se, input logic so,
                                     input logic sw, input logic we, input logic nw,
                                     input phase_e ph);
    logic [7:0] ring;
    logic [3:0] trans;
    logic [3:0] cnt;
    logic       m1;
    logic       m2;
    ring  = {nw, we, sw, so, se, ea, ne, n};
    trans = 4'd0;
    cnt   = 4'd0;
    for (int i = 0; i < 8; i++) begin
      trans = trans + 4'(!ring[i] && ring[(i + 1) % 8]);
      cnt   = cnt + 4'(ring[i]);
    end
    if (ph == PH_FIRST) begin
      m1 = n & ea & so;
      m2 = ea & so & we;
    end else begin
      m1 = n & ea & we;
      m2 = n & so & we;
    end
    return ctr && (trans == 4'd1) && (cnt >= NB_MIN) && (cnt <= NB_MAX) && !m1 && !m2;
  endfunction

endpackage

/* src/bitu_store.sv */
// ---------------------------------------------------------------------------
// bitu_store
// image row memory, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module bitu_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/bitu_thin_row.sv */
// ---------------------------------------------------------------------------
// bitu_thin_row
// one sub-iteration over a full row from a three-row window
// ---------------------------------------------------------------------------
module bitu_thin_row #(
  parameter int unsigned WIDTH = 64
) (
  input  logic [WIDTH-1:0] prev_i,
  input  logic [WIDTH-1:0] cur_i,
  input  logic [WIDTH-1:0] next_i,
  input  logic [WIDTH-1:0] col_en_i,
  input  bitu_pkg::phase_e phase_i,
  output logic [WIDTH-1:0] row_o,
  output logic             any_o
);
  import bitu_pkg::*;

  logic [WIDTH-1:0] marks;

  assign marks[0]       = 1'b0;
  assign marks[WIDTH-1] = 1'b0;

  for (genvar x = 1; x < WIDTH - 1; x++) begin : g_col
    assign marks[x] = col_en_i[x] &&
                      zs_delete(cur_i[x], prev_i[x], prev_i[x+1], cur_i[x+1],
                                next_i[x+1], next_i[x], next_i[x-1], cur_i[x-1],
                                prev_i[x-1], phase_i);
  end

  assign row_o = cur_i & ~marks;
  assign any_o = |marks;

endmodule

/* src/binary_image_thinning_unit.sv */
// ---------------------------------------------------------------------------
// binary_image_thinning_unit
// zhang-suen thinning of a binary image loaded one row per item
// ---------------------------------------------------------------------------
// Rows are taken one per cycle and written to a single-port-write row memory.
// The item flagged last_row starts thinning; in_stall_o then stays high until
// the last thinned row has been taken. Each sub-iteration walks the stored
// rows once through the memory read port with a three-row window, writes each
// interior row back in place; passes of two sub-iterations repeat until one
// clears nothing. Thinned rows then go from memory to the output register one
// at a time; each read waits for the previous row to load and the register
// to be free or taken. Images under 4 rows or columns skip thinning. Pixels at
// or above image_width read back as zero; rows past MAX_HEIGHT are dropped.
// ---------------------------------------------------------------------------
`include "binary_image_thinning_unit_defines.svh"

module binary_image_thinning_unit #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bitu_pkg::ROW_BITS-1:0]       row_bits_i,
  input  logic                                last_row_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bitu_pkg::ROW_BITS-1:0]       out_row_bits_o,
  output logic                                out_last_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bitu_pkg::PADDR_W-1:0]        paddr,
  input  logic [bitu_pkg::PDATA_W-1:0]        pwdata,
  output logic [bitu_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import bitu_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_HEIGHT);
  localparam int unsigned CNT_W = $clog2(MAX_HEIGHT + 1);

  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic                 changed_q, changed_d;
  logic [CNT_W-1:0]     rows_q, rows_d;
  logic [CNT_W-1:0]     ptr_q, ptr_d;
  logic                 rdv_q;
  logic [AW-1:0]        rd_row_q;
  logic [CFG_W-1:0]     width_q;
  logic                 out_valid_q, out_valid_d;
  logic                 out_last_q;
  logic [MAX_WIDTH-1:0] out_q;
  logic [MAX_WIDTH-1:0] prev_q, cur_q;

  logic [CFG_W-1:0]     w_eff;
  logic [MAX_WIDTH-1:0] col_mask;
  logic [MAX_WIDTH-1:0] col_en;
  logic [CNT_W-1:0]     rows_m1;
  logic [AW-1:0]        last_idx;

  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [MAX_WIDTH-1:0] mem_wr_data;
  logic                 mem_rd_en;
  logic [MAX_WIDTH-1:0] mem_rd_data;
  logic [MAX_WIDTH-1:0] rd_masked;
  logic [MAX_WIDTH-1:0] thin_row;
  logic                 thin_any;
  logic                 out_load;
  logic                 chg;

  // configuration
  assign pready = 1'b1;
  assign prdata = PDATA_W'(width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_IMAGE_WIDTH) begin
      width_q <= pwdata[CFG_W-1:0];
    end
  end

  assign w_eff = (width_q > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_q;

  always_comb begin
    for (int k = 0; k < MAX_WIDTH; k++) begin
      col_mask[k] = CFG_W'(k) < w_eff;
    end
  end

  // interior columns only
  assign col_en    = col_mask & (col_mask >> 1) & ~MAX_WIDTH'(1);
  assign rd_masked = mem_rd_data & col_mask;
  assign rows_m1   = rows_q - CNT_W'(1);
  assign last_idx  = rows_m1[AW-1:0];

  bitu_store #(
    .DEPTH (MAX_HEIGHT),
    .WIDTH (MAX_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (ptr_q[AW-1:0]),
    .rd_data_o (mem_rd_data)
  );

  bitu_thin_row #(
    .WIDTH (MAX_WIDTH)
  ) u_thin (
    .prev_i   (prev_q),
    .cur_i    (cur_q),
    .next_i   (rd_masked),
    .col_en_i (col_en),
    .phase_i  (phase_q),
    .row_o    (thin_row),
    .any_o    (thin_any)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    changed_d   = changed_q;
    rows_d      = rows_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    mem_rd_en   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = rows_q[AW-1:0];
    mem_wr_data = row_bits_i[MAX_WIDTH-1:0];
    chg         = changed_q;
    in_stall_o  = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (rows_q < CNT_W'(MAX_HEIGHT)) begin
            mem_wr_en = 1'b1;
            rows_d    = rows_q + CNT_W'(1);
          end
          if (last_row_i) begin
            ptr_d     = '0;
            phase_d   = PH_FIRST;
            changed_d = 1'b0;
            if (rows_d >= CNT_W'(MIN_DIM) && w_eff >= CFG_W'(MIN_DIM)) begin
              state_d = ST_THIN;
            end else begin
              state_d = ST_OUT;
            end
          end
        end
      end
      ST_THIN: begin
        if (ptr_q < rows_q) begin
          mem_rd_en = 1'b1;
          ptr_d     = ptr_q + CNT_W'(1);
        end
        if (rdv_q && rd_row_q >= AW'(2)) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = rd_row_q - AW'(1);
          mem_wr_data = thin_row;
          chg         = changed_q | thin_any;
        end
        changed_d = chg;
        if (rdv_q && rd_row_q == last_idx) begin
          ptr_d = '0;
          if (phase_q == PH_FIRST) begin
            phase_d = PH_SECOND;
          end else if (chg) begin
            phase_d   = PH_FIRST;
            changed_d = 1'b0;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (ptr_q < rows_q && !rdv_q && (!out_valid_q || !out_stall_i)) begin
          mem_rd_en = 1'b1;
          ptr_d     = ptr_q + CNT_W'(1);
        end
        if (out_valid_q && !out_stall_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = ST_IDLE;
            rows_d  = '0;
          end
        end
        if (rdv_q) begin
          out_valid_d = 1'b1;
          out_load    = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FIRST;
      changed_q   <= 1'b0;
      rows_q      <= '0;
      ptr_q       <= '0;
      rdv_q       <= 1'b0;
      rd_row_q    <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      changed_q   <= changed_d;
      rows_q      <= rows_d;
      ptr_q       <= ptr_d;
      rdv_q       <= mem_rd_en;
      out_valid_q <= out_valid_d;
      if (mem_rd_en) begin
        rd_row_q <= ptr_q[AW-1:0];
      end
      if (out_load) begin
        out_last_q <= (rd_row_q == last_idx);
      end
    end
  end

  // row window and output payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_THIN && rdv_q) begin
      prev_q <= cur_q;
      cur_q  <= rd_masked;
    end
    if (out_load) begin
      out_q <= rd_masked;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_row_bits_o = ROW_BITS'(out_q);
  assign out_last_o     = out_last_q;

  `BITU_ASSERT_IMP(a_idle_no_out, clk_i, rst_ni, !in_stall_o, !out_valid_q && !rdv_q, "item taken while work pending")
  `BITU_ASSERT_IMP(a_rw_distinct, clk_i, rst_ni, state_q == ST_THIN && mem_wr_en && mem_rd_en, mem_wr_addr != ptr_q[AW-1:0], "write and read hit the same row")
  `BITU_ASSERT_IMP(a_out_slot_free, clk_i, rst_ni, state_q == ST_OUT && rdv_q, !out_valid_q, "read data arrived with output register full")
  `BITU_ASSERT_IMP(a_row_in_range, clk_i, rst_ni, rdv_q, CNT_W'(rd_row_q) < rows_q, "read row beyond loaded rows")
  `BITU_ASSERT_IMP(a_thin_size, clk_i, rst_ni, state_q == ST_THIN, rows_q >= CNT_W'(MIN_DIM) && w_eff >= CFG_W'(MIN_DIM), "thinning a small image")

endmodule

/* dv/bitu_row_checker.sv */
// ---------------------------------------------------------------------------
// bitu_row_checker
// watches the row channels and the register port of the thinning unit,
// keeps its own copy of the loaded image and image_width, thins the image
// when the last row is taken and compares every thinned row leaving the
// block, in order, with the rows it worked out
// ---------------------------------------------------------------------------
module bitu_row_checker #(
  parameter int unsigned                   MAX_W      = 64,
  parameter int unsigned                   MAX_H      = 64,
  parameter logic [bitu_pkg::PADDR_W-1:0]  WIDTH_ADDR = '0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [bitu_pkg::ROW_BITS-1:0] row_bits_i,
  input  logic                          last_row_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [bitu_pkg::ROW_BITS-1:0] out_row_bits_o,
  input  logic                          out_last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bitu_pkg::PADDR_W-1:0]  paddr,
  input  logic [bitu_pkg::PDATA_W-1:0]  pwdata,
  input  logic                          pready,
  output int                            mismatches_o,
  output int                            pending_o,
  output int                            rows_checked_o
);
  import bitu_pkg::*;

  typedef struct packed {
    logic [ROW_BITS-1:0] bits;
    logic                last;
  } thin_row_t;

  thin_row_t           rows_due[$];
  thin_row_t           head;
  thin_row_t           tail;
  logic [ROW_BITS-1:0] image_rows [MAX_H];
  logic [ROW_BITS-1:0] col_mask;
  logic [CFG_W-1:0]    width_reg;
  int unsigned         rows_held;
  int unsigned         eff_w;
  bit                  moved_first;
  bit                  moved_second;
  int                  mismatches;
  int                  rows_checked;

  assign mismatches_o   = mismatches;
  assign rows_checked_o = rows_checked;

  task automatic flag_mismatch(input string what, input logic [ROW_BITS-1:0] got,
                               input logic [ROW_BITS-1:0] want);
    mismatches++;
    $display("%0t mismatch: %s got %h expected %h", $time, what, got, want);
  endtask

  // one sub-iteration over the held image, true when any pixel was cleared
  function automatic bit thin_subpass(input int unsigned h, input int unsigned w,
                                      input phase_e ph);
    logic [ROW_BITS-1:0] clr [MAX_H];
    logic [7:0]          ring;
    int                  trans;
    int                  cnt;
    bit                  n, ne, e, se, s, sw, wv, nw, p1, p2, hit;
    hit = 1'b0;
    for (int y = 0; y < MAX_H; y++) clr[y] = '0;
    for (int y = 1; y + 1 < h; y++) begin
      for (int x = 1; x + 1 < w; x++) begin
        if (!image_rows[y][x]) continue;
        n  = image_rows[y-1][x];
        ne = image_rows[y-1][x+1];
        e  = image_rows[y][x+1];
        se = image_rows[y+1][x+1];
        s  = image_rows[y+1][x];
        sw = image_rows[y+1][x-1];
        wv = image_rows[y][x-1];
        nw = image_rows[y-1][x-1];
        ring  = {nw, wv, sw, s, se, e, ne, n};
        trans = 0;
        for (int k = 0; k < 8; k++) trans += (!ring[k] && ring[(k + 1) % 8]);
        cnt = $countones(ring);
        if (ph == PH_FIRST) begin
          p1 = n & e & s;
          p2 = e & s & wv;
        end else begin
          p1 = n & e & wv;
          p2 = n & s & wv;
        end
        if (trans == 1 && cnt >= 2 && cnt <= 6 && !p1 && !p2) clr[y][x] = 1'b1;
      end
    end
    for (int y = 0; y < h; y++) begin
      if (clr[y] != '0) begin
        image_rows[y] &= ~clr[y];
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_due.delete();
      rows_held    = 0;
      width_reg    = WIDTH_RESET;
      mismatches   = 0;
      rows_checked = 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (rows_due.size() == 0) begin
          flag_mismatch("thinned row with none expected", out_row_bits_o, '0);
        end else begin
          head = rows_due.pop_front();
          rows_checked++;
          if (out_row_bits_o !== head.bits)
            flag_mismatch("out_row_bits", out_row_bits_o, head.bits);
          if (out_last_o !== head.last)
            flag_mismatch("out_last", ROW_BITS'(out_last_o), ROW_BITS'(head.last));
        end
      end
      if (psel && penable && pwrite && pready && paddr == WIDTH_ADDR)
        width_reg = pwdata[CFG_W-1:0];
      if (in_valid_i && !in_stall_o) begin
        if (rows_held < MAX_H) begin
          image_rows[rows_held] = row_bits_i;
          rows_held++;
        end
        if (last_row_i) begin
          eff_w    = (width_reg > MAX_W) ? MAX_W : width_reg;
          col_mask = (eff_w >= ROW_BITS) ? '1 : ((ROW_BITS'(1) << eff_w) - 1);
          for (int y = 0; y < rows_held; y++) image_rows[y] &= col_mask;
          if (rows_held >= MIN_DIM && eff_w >= MIN_DIM) begin
            do begin
              moved_first  = thin_subpass(rows_held, eff_w, PH_FIRST);
              moved_second = thin_subpass(rows_held, eff_w, PH_SECOND);
            end while (moved_first || moved_second);
          end
          for (int y = 0; y < rows_held; y++) begin
            tail.bits = image_rows[y] & col_mask;
            tail.last = (y + 1 == rows_held);
            rows_due  = {rows_due, tail};
          end
          rows_held = 0;
        end
      end
      pending_o <= rows_due.size();
    end
  end

endmodule

/* dv/tb_binary_image_thinning_unit.sv */
// ---------------------------------------------------------------------------
// tb_binary_image_thinning_unit
// loads binary images row by row into the thinning unit and checks the
// thinned rows: a directed set of corner images (solid, empty, too short,
// too narrow, zero and oversized widths) and then random noise, solid,
// blob and holed images under several idle and stall mixes, including a
// long output hold-off and an image taller than the row store
// ---------------------------------------------------------------------------
module tb_binary_image_thinning_unit;
  import bitu_pkg::*;

  localparam int unsigned        MAX_W            = 64;
  localparam int unsigned        MAX_H            = 64;
  localparam logic [PADDR_W-1:0] IMAGE_WIDTH_ADDR = REG_IMAGE_WIDTH;
  localparam int unsigned        RANDOM_ROWS      = 85;

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_BLOB,
    SHAPE_HOLED,
    SHAPE_SOLID,
    SHAPE_EMPTY
  } shape_e;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [ROW_BITS-1:0] row_bits_i     = '0;
  logic                last_row_i     = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [ROW_BITS-1:0] out_row_bits_o;
  logic                out_last_o;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [PADDR_W-1:0]  paddr          = '0;
  logic [PDATA_W-1:0]  pwdata         = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int          mismatches;
  int          pending;
  int          rows_checked;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_cycles   = 0;
  int          rows_sent     = 0;
  int          rows_dropped  = 0;
  int          images_sent   = 0;
  int          random_rows   = 0;
  logic [6:0]  width_now     = 7'd64;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  binary_image_thinning_unit #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .row_bits_i     (row_bits_i),
    .last_row_i     (last_row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_row_bits_o (out_row_bits_o),
    .out_last_o     (out_last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  bitu_row_checker #(
    .MAX_W      (MAX_W),
    .MAX_H      (MAX_H),
    .WIDTH_ADDR (IMAGE_WIDTH_ADDR)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .row_bits_i     (row_bits_i),
    .last_row_i     (last_row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_row_bits_o (out_row_bits_o),
    .out_last_o     (out_last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .rows_checked_o (rows_checked)
  );

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [ROW_BITS-1:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  // only between images, once the block has drained
  task automatic set_width(input logic [6:0] w);
    wait (pending == 0);
    repeat (8) @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= IMAGE_WIDTH_ADDR;
    pwdata  <= {25'($urandom), w};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    width_now = w;
  endtask

  task automatic send_row(input logic [ROW_BITS-1:0] bits, input logic last);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    row_bits_i <= bits;
    last_row_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    rows_sent++;
  endtask

  task automatic send_image(input int h, input shape_e shape);
    int unsigned         wd;
    int unsigned         lft;
    int unsigned         rgt;
    int                  top_y;
    int                  bot_y;
    logic [ROW_BITS-1:0] band;
    logic [ROW_BITS-1:0] wmask;
    logic [ROW_BITS-1:0] bits;
    wd    = (width_now > MAX_W) ? MAX_W : width_now;
    wmask = (wd >= ROW_BITS) ? '1 : ((ROW_BITS'(1) << wd) - 1);
    lft   = (wd > 0) ? $urandom_range(0, wd / 3) : 0;
    rgt   = (wd > 1) ? $urandom_range(wd / 2, wd - 1) : 0;
    band  = ((ROW_BITS'(1) << (rgt + 1)) - 1) & ~((ROW_BITS'(1) << lft) - 1);
    top_y = $urandom_range(0, h / 3);
    bot_y = $urandom_range(h / 2, h - 1);
    for (int y = 0; y < h; y++) begin
      case (shape)
        SHAPE_NOISE: bits = rand_row();
        SHAPE_SOLID: bits = '1;
        SHAPE_EMPTY: bits = '0;
        default: begin
          bits = (y >= top_y && y <= bot_y) ? band : '0;
          if (shape == SHAPE_HOLED) bits &= ~(rand_row() & rand_row() & rand_row());
          if ($urandom_range(0, 3) == 0) bits |= rand_row() & rand_row() & rand_row();
          bits |= rand_row() & ~wmask;
        end
      endcase
      send_row(bits, y == h - 1);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    images_sent++;
    if (h > MAX_H) rows_dropped += h - MAX_H;
  endtask

  function automatic logic [6:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 7'd64;
    if (r < 45) return 7'd4;
    if (r < 80) return 7'($urandom_range(5, 63));
    if (r < 90) return 7'($urandom_range(65, 127));
    return 7'($urandom_range(0, 3));
  endfunction

  function automatic shape_e pick_shape();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return SHAPE_NOISE;
    if (r < 55) return SHAPE_BLOB;
    if (r < 90) return SHAPE_HOLED;
    return SHAPE_SOLID;
  endfunction

  initial begin
    int idx;
    int h;
    int r;
    int start_rows;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // corner images, first one at the reset width
    send_image(4, SHAPE_SOLID);
    send_image(1, SHAPE_EMPTY);
    send_image(2, SHAPE_NOISE);
    send_image(5, SHAPE_BLOB);
    set_width(7'd3);
    send_image(4, SHAPE_SOLID);
    set_width(7'd0);
    send_image(1, SHAPE_SOLID);
    set_width(7'd127);
    send_image(4, SHAPE_NOISE);
    set_width(7'd4);
    send_image(4, SHAPE_SOLID);

    idx = 0;
    while (random_rows < RANDOM_ROWS) begin
      case (idx % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      if (idx == 4) set_width(7'd64);
      else if (idx % 3 == 0) set_width(pick_width());
      r = $urandom_range(0, 99);
      h = (idx == 4) ? MAX_H + 2 : (r < 15) ? $urandom_range(1, 3) : $urandom_range(4, 9);
      // hold the output side while the next image queues up behind it
      if (idx == 1) hold_cycles = 300;
      if (idx == 6) begin
        wait (pending == 0);
        @(negedge clk_i);
      end
      start_rows = rows_sent;
      send_image(h, pick_shape());
      random_rows += rows_sent - start_rows;
      idx++;
    end

    wait (pending == 0);
    repeat (60) @(posedge clk_i);
    $display("covered %0d images, %0d rows (%0d past the row store), %0d thinned rows checked",
             images_sent, rows_sent, rows_dropped, rows_checked);
    $display("widths 0, 3, 4, 64 and above 64 exercised, with an output hold-off and idle mixes");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/bitu_pkg.sv
src/bitu_store.sv
src/bitu_thin_row.sv
src/binary_image_thinning_unit.sv
dv/bitu_row_checker.sv
dv/tb_binary_image_thinning_unit.sv
